### src/qsu_pkg.sv
package qsu_pkg;

	localparam int BYTE_W  = 8;
	localparam int REPORT_W = 16;

	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
	localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
	localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
	localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

	localparam logic STYLE_SINGLE = 1'b0;
	localparam logic STYLE_DOUBLE = 1'b1;

	typedef enum logic [2:0] {
		CAUSE_NONE   = 3'd0,
		CAUSE_END    = 3'd1,
		CAUSE_QUOTE  = 3'd2,
		CAUSE_NUL    = 3'd3,
		CAUSE_ESCAPE = 3'd4
	} cause_t;

	typedef struct packed {
		logic                  out_valid;
		logic [BYTE_W-1:0]     out_byte;
		logic                  stopped;
		cause_t                stop_cause;
		logic [REPORT_W-1:0]   decoded_count;
	} result_t;

	function automatic logic [BYTE_W-1:0] unescape(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		case (c)
			CH_ZERO: r = CH_NUL;
			CH_T:    r = CH_TAB;
			CH_R:    r = CH_CR;
			CH_N:    r = CH_LF;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

### src/qsu_decode.sv
module qsu_decode
	import qsu_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              last,
	input  logic              quote_style,
	output result_t           result
);

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_ESCAPE = 2'd1,
		PH_QUOTE  = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	phase_t                 phase_q;
	phase_t                 phase_d;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   emit;
	logic [BYTE_W-1:0]      ch;
	cause_t                 cause;
	logic [31:0]            count_ext;

	always_comb begin
		emit    = 1'b0;
		ch      = CH_NUL;
		cause   = CAUSE_NONE;
		phase_d = phase_q;
		case (phase_q)
			PH_NORMAL: begin
				if (in_byte == CH_NUL) begin
					cause = CAUSE_NUL;
				end else if (in_byte == CH_BSLASH) begin
					if (last) cause = CAUSE_ESCAPE;
					else phase_d = PH_ESCAPE;
				end else if (quote_style == STYLE_SINGLE && in_byte == CH_SQUOTE) begin
					if (last) cause = CAUSE_QUOTE;
					else phase_d = PH_QUOTE;
				end else if (quote_style == STYLE_DOUBLE && in_byte == CH_DQUOTE) begin
					cause = CAUSE_QUOTE;
				end else begin
					emit = 1'b1;
					ch   = in_byte;
				end
			end
			PH_ESCAPE: begin
				if (in_byte == CH_NUL) begin
					cause = CAUSE_NUL;
				end else begin
					emit    = 1'b1;
					ch      = unescape(in_byte);
					phase_d = PH_NORMAL;
				end
			end
			PH_QUOTE: begin
				// doubled quote is a literal quote, anything else closes
				if (in_byte == CH_SQUOTE) begin
					emit    = 1'b1;
					ch      = CH_SQUOTE;
					phase_d = PH_NORMAL;
				end else begin
					cause = CAUSE_QUOTE;
				end
			end
			default: begin
			end
		endcase

		if (cause != CAUSE_NONE) phase_d = PH_DONE;
		else if (last && phase_q != PH_DONE) cause = CAUSE_END;

		count_d = count_q;
		if (emit && !(&count_q)) count_d = count_q + COUNT_WIDTH'(1);
		count_ext = 32'(count_d);

		result.out_valid     = emit;
		result.out_byte      = ch;
		result.stopped       = (cause != CAUSE_NONE);
		result.stop_cause    = cause;
		result.decoded_count = (count_ext > 32'h0000_FFFF) ? {REPORT_W{1'b1}}
			: count_ext[REPORT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			count_q <= '0;
		end else if (step) begin
			if (last) begin
				phase_q <= PH_NORMAL;
				count_q <= '0;
			end else begin
				phase_q <= phase_d;
				count_q <= count_d;
			end
		end
	end

`ifndef ASSERT_OFF
	a_cnt_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result.out_valid |-> (result.decoded_count != '0))
		else $error("emit with zero count");
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> (!result.out_valid && !result.stopped))
		else $error("output after decoding ended");
	a_reset_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last) |=> (phase_q == PH_NORMAL && count_q == '0))
		else $error("state not cleared after last word");
`endif

endmodule

### src/quoted_string_unescaper_core.sv
// Path: input word accept into the input register, then decode, then the result register.
// Throughput: 1 word per cycle while the result stream is not stalled; the phase/count update does not hold the flow.
// Output stall backs up through the input register; no word is dropped.
// Reset (arst_n low, async): both stages empty, parse phase normal, count zero,
// quote_style single.
module quoted_string_unescaper_core
	import qsu_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config: quote_style, 0 single with doubling, 1 double
	input  logic        quote_style_we,
	input  logic        quote_style_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // last byte of the quoted region
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] out_byte, [8] stopped, [11:9] stop_cause,
	                               // [27:12] decoded_count, [31:28] zero
	output logic        m_tuser    // [0] out_valid
);

	logic              quote_style_q;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// result register
	logic              valid_s2;
	result_t           res_s2;

	result_t           res_d;
	logic              advance;

	// s1 moves into s2 when s2 is free or being drained this cycle
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_style_q <= STYLE_SINGLE;
		end else if (quote_style_we) begin
			quote_style_q <= quote_style_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// decode logic plus the phase / count state it updates
	qsu_decode #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.in_byte     (byte_s1),
		.last        (last_s1),
		.quote_style (quote_style_q),
		.result      (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.out_valid;
	assign m_tdata  = {4'b0000, res_s2.decoded_count, res_s2.stop_cause,
		res_s2.stopped, res_s2.out_byte};

`ifndef ASSERT_OFF
	a_stop_matches_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.stopped == (res_s2.stop_cause != CAUSE_NONE)))
		else $error("stopped flag and cause disagree");
	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.out_valid) |-> (res_s2.out_byte == CH_NUL))
		else $error("nonzero byte without out_valid");
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register not loaded");
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input blocked with empty input register");
`endif

endmodule

### test/testbench.sv
module testbench;
	import qsu_pkg::*;

	// parse state of the predictor, same encoding as the block keeps internally
	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_ESCAPE = 2'd1,
		PH_QUOTE  = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	// one row of the directed table: either a byte to send or a style write
	typedef enum logic {
		ROW_WORD  = 1'b0,
		ROW_STYLE = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [7:0] val;   // byte, or the style in bit 0
		logic       fin;   // tlast
		logic       chk;   // 1: compare against want, 0: against the predictor
		result_t    want;
	} dir_row_t;

	localparam int          RANDOM_WORDS = 1250;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          LIMIT_CYCLES = 600000;
	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
	localparam int          N_DIR        = 31;

	// row filler for rows checked by the predictor
	localparam result_t NO_WANT = '{1'b0, 8'h00, 1'b0, CAUSE_NONE, 16'd0};

	// Directed part. Starts in single style (reset value).
	localparam dir_row_t DIR_TAB [N_DIR] = '{
		// backslash right after reset: nothing out, count still zero
		'{ROW_WORD, CH_BSLASH, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, CAUSE_NONE, 16'd0}},
		'{ROW_WORD, CH_N,      1'b0, 1'b1, '{1'b1, CH_LF, 1'b0, CAUSE_NONE, 16'd1}},
		// remaining escapes: \0 \t \r and a pass-through backslash
		'{ROW_WORD, CH_BSLASH, 1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, CH_ZERO,   1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, CH_BSLASH, 1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, CH_T,      1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, CH_BSLASH, 1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, CH_R,      1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, CH_BSLASH, 1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, CH_BSLASH, 1'b0, 1'b0, NO_WANT},
		// doubled quote gives one quote
		'{ROW_WORD, CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
		// top byte on tlast: still emitted, end of region
		'{ROW_WORD, 8'hFF,     1'b1, 1'b1, '{1'b1, 8'hFF, 1'b1, CAUSE_END, 16'd7}},
		// lone quote closes at the following byte, later bytes ignored
		'{ROW_WORD, CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, 8'h01,     1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, CAUSE_QUOTE, 16'd0}},
		'{ROW_WORD, CH_DQUOTE, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, CAUSE_NONE, 16'd0}},
		// quote as the last byte
		'{ROW_WORD, CH_SQUOTE, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, CAUSE_QUOTE, 16'd0}},
		// dangling backslash
		'{ROW_WORD, CH_BSLASH, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, CAUSE_ESCAPE, 16'd0}},
		// bare NUL
		'{ROW_WORD, CH_NUL,    1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, CAUSE_NUL, 16'd0}},
		// escaped NUL, then an ignored byte
		'{ROW_WORD, CH_BSLASH, 1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, CH_NUL,    1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, CAUSE_NUL, 16'd0}},
		'{ROW_WORD, 8'h7A,     1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, CAUSE_NONE, 16'd0}},
		// pending quote survives a switch to double style and still pairs up
		'{ROW_WORD, CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
		'{ROW_STYLE, 8'(STYLE_DOUBLE), 1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, CH_SQUOTE, 1'b0, 1'b1, '{1'b1, CH_SQUOTE, 1'b0, CAUSE_NONE, 16'd1}},
		'{ROW_WORD, CH_DQUOTE, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, CAUSE_QUOTE, 16'd1}},
		// single quote is plain text in double style
		'{ROW_WORD, CH_SQUOTE, 1'b1, 1'b1, '{1'b1, CH_SQUOTE, 1'b1, CAUSE_END, 16'd1}},
		// pending quote then switch to double: non-quote still closes
		'{ROW_STYLE, 8'(STYLE_SINGLE), 1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
		'{ROW_STYLE, 8'(STYLE_DOUBLE), 1'b0, 1'b0, NO_WANT},
		'{ROW_WORD, 8'h78,     1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, CAUSE_QUOTE, 16'd0}}
	};

	logic        clk;
	logic        arst_n;
	logic        quote_style_we;
	logic        quote_style_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] in_byte
	logic        s_tlast;   // last byte of the region
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [7:0] out_byte, [8] stopped, [11:9] stop_cause,
	                        // [27:12] decoded_count
	logic        m_tuser;   // [0] out_valid

	quoted_string_unescaper_core #(
		.COUNT_WIDTH(16)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.quote_style_we   (quote_style_we),
		.quote_style_wdata(quote_style_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tlast          (s_tlast),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser)
	);

	// predictor state: our own copy of the style register, phase and count
	logic        style_model;
	phase_t      ph_model;
	logic [15:0] count_model;

	// decoded words still owed by the block, oldest first
	result_t pending_results [$];

	// traffic shaping, shared between the stimulus and the receiver
	int tx_gap_max;   // 0: sender never idles
	int tx_burst;     // words left in the current burst
	bit tx_driving;   // tracks what we last put on s_tvalid
	int rx_mode;      // 0: always ready, 1: pattern, 2: stall-heavy pattern
	bit hold_req;     // asks the receiver for one long hold-off

	// statistics and errors
	int n_errors;
	int n_words;
	int n_live;       // words that were not ignored after a stop
	int n_stopped;
	int n_style_writes;
	int n_results;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Predict one word. Advances the predictor state; a tlast word puts it
	// back to normal phase and zero count afterwards.
	function automatic result_t decode_step(input logic [7:0] b, input logic fin);
		result_t    r;
		logic       emit;
		logic [7:0] ch;
		cause_t     why;
		phase_t     nxt;
		emit = 1'b0;
		ch   = 8'h00;
		why  = CAUSE_NONE;
		nxt  = ph_model;
		case (ph_model)
			PH_NORMAL: begin
				if (b == CH_NUL) begin
					why = CAUSE_NUL;
				end else if (b == CH_BSLASH) begin
					if (fin)
						why = CAUSE_ESCAPE;
					else
						nxt = PH_ESCAPE;
				end else if (style_model == STYLE_SINGLE && b == CH_SQUOTE) begin
					if (fin)
						why = CAUSE_QUOTE;
					else
						nxt = PH_QUOTE;
				end else if (style_model == STYLE_DOUBLE && b == CH_DQUOTE) begin
					why = CAUSE_QUOTE;
				end else begin
					emit = 1'b1;
					ch   = b;
				end
			end
			PH_ESCAPE: begin
				if (b == CH_NUL) begin
					why = CAUSE_NUL;
				end else begin
					emit = 1'b1;
					case (b)
						CH_ZERO: ch = CH_NUL;
						CH_T:    ch = CH_TAB;
						CH_R:    ch = CH_CR;
						CH_N:    ch = CH_LF;
						default: ch = b;
					endcase
					nxt = PH_NORMAL;
				end
			end
			// pending quote follows the single-style rule whatever the style is now
			PH_QUOTE: begin
				if (b == CH_SQUOTE) begin
					emit = 1'b1;
					ch   = CH_SQUOTE;
					nxt  = PH_NORMAL;
				end else begin
					why = CAUSE_QUOTE;
				end
			end
			default: ;
		endcase

		if (emit && count_model != COUNT_MAX)
			count_model = count_model + 16'd1;
		if (why != CAUSE_NONE)
			nxt = PH_DONE;
		else if (fin && ph_model != PH_DONE)
			why = CAUSE_END;

		r.out_valid     = emit;
		r.out_byte      = ch;
		r.stopped       = (why != CAUSE_NONE);
		r.stop_cause    = why;
		r.decoded_count = count_model;

		n_words++;
		if (ph_model != PH_DONE)
			n_live++;
		if (r.stopped)
			n_stopped++;

		if (fin) begin
			ph_model    = PH_NORMAL;
			count_model = 16'd0;
		end else begin
			ph_model = nxt;
		end
		return r;
	endfunction

	// Offer one word and hold it until accepted; then either continue the
	// burst (valid stays high) or drop valid for a random gap.
	task automatic send_word(input logic [7:0] b, input logic fin, input logic chk,
	                         input result_t want);
		result_t pred;
		int      gap;
		s_tvalid   <= 1'b1;
		s_tdata    <= b;
		s_tlast    <= fin;
		tx_driving  = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = decode_step(b, fin);
		pending_results.push_back(chk ? want : pred);
		if (tx_burst > 0) begin
			tx_burst--;
		end else begin
			tx_burst = $urandom_range(0, 12);
			if (tx_gap_max > 0) begin
				gap        = $urandom_range(1, tx_gap_max);
				s_tvalid  <= 1'b0;
				tx_driving = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Style writes only with nothing in flight. Parse state is kept, so a
	// write between two words of one string is a mid-string style change.
	task automatic set_style(input logic v);
		if (tx_driving) begin
			s_tvalid  <= 1'b0;
			tx_driving = 1'b0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		quote_style_we    <= 1'b1;
		quote_style_wdata <= v;
		@(posedge clk);
		quote_style_we <= 1'b0;
		style_model = v;
		n_style_writes++;
	endtask

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("ERROR: result word %0d: %s is 0x%0h, expected 0x%0h", n_results, what,
		         got, want);
		n_errors++;
	endtask

	// One random string, mostly well-formed tokens, with a random closing.
	task automatic send_string();
		logic [7:0] str [$];
		int         target;
		int         k;
		int         flip_at;
		target = $urandom_range(1, 16);
		while (str.size() < target) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: str.push_back(8'($urandom_range(8'h61, 8'h7A)));
				5, 6, 7:       str.push_back(8'($urandom_range(8'h30, 8'h5A)));
				8, 9: begin
					str.push_back(CH_BSLASH);
					case ($urandom_range(0, 3))
						0: str.push_back(CH_ZERO);
						1: str.push_back(CH_T);
						2: str.push_back(CH_R);
						default: str.push_back(CH_N);
					endcase
				end
				10: begin
					str.push_back(CH_BSLASH);
					str.push_back(8'($urandom_range(1, 255)));
				end
				11, 12: begin
					str.push_back(CH_SQUOTE);
					str.push_back(CH_SQUOTE);
				end
				13:     str.push_back(CH_DQUOTE);
				14:     str.push_back(CH_SQUOTE);
				15, 16: str.push_back(8'($urandom_range(8'h80, 8'hFF)));
				17:     str.push_back(8'($urandom_range(0, 255)));
				18:     str.push_back(8'($urandom_range(1, 127)));
				default: str.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : 8'h41);
			endcase
		end
		// closing: real quote with trailing junk, a dangling backslash, or nothing
		case ($urandom_range(0, 5))
			0: begin
				str.push_back(style_model == STYLE_DOUBLE ? CH_DQUOTE : CH_SQUOTE);
				repeat ($urandom_range(0, 2))
					str.push_back(8'($urandom_range(0, 255)));
			end
			1: str.push_back(CH_BSLASH);
			default: ;
		endcase
		flip_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, str.size()) : -1;
		for (k = 0; k < str.size(); k++) begin
			if (k == flip_at)
				set_style(~style_model);
			send_word(str[k], k == str.size() - 1, 1'b0, NO_WANT);
		end
	endtask

	// Receiver: its own rotating ready pattern, redrawn now and then, plus one
	// long hold-off on request so the block backs up into its input.
	initial begin : receiver
		logic [15:0] pat;
		int          age;
		m_tready = 1'b0;
		pat      = 16'hA5C3;
		age      = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				case (rx_mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= pat[0];
					default: m_tready <= pat[0] & pat[5];
				endcase
				pat = {pat[0], pat[15:1]};
				age++;
				if (age == 48) begin
					age = 0;
					pat = 16'($urandom());
				end
			end
		end
	end

	// Result checker: every accepted result word against the oldest prediction.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("word with nothing pending, tdata", int'(m_tdata), 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.out_valid)
					note_mismatch("out_valid", int'(m_tuser), int'(want.out_valid));
				if (m_tdata[7:0] !== want.out_byte)
					note_mismatch("out_byte", int'(m_tdata[7:0]), int'(want.out_byte));
				if (m_tdata[8] !== want.stopped)
					note_mismatch("stopped", int'(m_tdata[8]), int'(want.stopped));
				if (m_tdata[11:9] !== want.stop_cause)
					note_mismatch("stop_cause", int'(m_tdata[11:9]), int'(want.stop_cause));
				if (m_tdata[27:12] !== want.decoded_count)
					note_mismatch("decoded_count", int'(m_tdata[27:12]),
					              int'(want.decoded_count));
			end
			n_results++;
		end
	end

	// Watchdog: a run that never drains ends here.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("ERROR: timeout after %0d cycles, %0d results still pending", cycles,
		         pending_results.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int i;
		int word_base;
		bit hold_done;
		arst_n            = 1'b0;
		quote_style_we    = 1'b0;
		quote_style_wdata = 1'b0;
		s_tvalid          = 1'b0;
		s_tdata           = 8'h00;
		s_tlast           = 1'b0;
		style_model       = STYLE_SINGLE;
		ph_model          = PH_NORMAL;
		count_model       = 16'd0;
		tx_gap_max        = 2;
		tx_burst          = 0;
		tx_driving        = 1'b0;
		rx_mode           = 1;
		hold_req          = 1'b0;
		hold_done         = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < N_DIR; i++) begin
			if (DIR_TAB[i].kind == ROW_STYLE)
				set_style(DIR_TAB[i].val[0]);
			else
				send_word(DIR_TAB[i].val, DIR_TAB[i].fin, DIR_TAB[i].chk, DIR_TAB[i].want);
		end

		// random strings; traffic shape changes every few strings
		word_base = n_words;
		while (n_words - word_base < RANDOM_WORDS) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 2))
					0:       tx_gap_max = 0;
					1:       tx_gap_max = 2;
					default: tx_gap_max = 6;
				endcase
				rx_mode = $urandom_range(0, 2);
			end
			if ($urandom_range(0, 5) == 0)
				set_style(1'($urandom_range(0, 1)));
			// halfway through: long receiver hold-off while we keep streaming
			if (!hold_done && n_words - word_base >= RANDOM_WORDS / 2) begin
				tx_gap_max = 0;
				hold_req   = 1'b1;
				hold_done  = 1'b1;
			end
			send_string();
		end

		if (tx_driving) begin
			s_tvalid  <= 1'b0;
			tx_driving = 1'b0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run: %0d words in (%0d decoded live, %0d past a stop), %0d results out",
		         n_words, n_live, n_words - n_live, n_results);
		$display("     %0d stopping results, %0d style writes, one long output hold-off",
		         n_stopped, n_style_writes);
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
